FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/bdq_pkg.sv
package bdq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_SEARCH     = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                    found;
    logic [POS_W-1:0]        match_position;
    logic [POS_W-1:0]        item_count;
    logic                    is_empty;
    logic [1:0]              status;
  } out_t;

endpackage

FILE: sv/bdq_ring_mem.sv
module bdq_ring_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/bounded_deque_with_search.sv
// Bounded deque of CAPACITY items held in a ring in one synchronous RAM, with
// head index and item count in registers. A command is taken when start is
// high and busy is low, and exactly one result follows, shown on out_item for
// a single cycle with out_strobe high; the receiver cannot stall it, so it
// must take every result as it appears. Push, pop, clear and unused codes
// are answered directly: the result appears the cycle after the command and a
// new command may be given in that same cycle. A read passes through the
// registered RAM read and the S_RDWAIT state. A search walks the ring one RAM
// read per cycle up to the first match or, on a miss, over all n items; a
// read of an out-of-range position or a search of an empty list is answered
// directly. No clearing pass is needed after reset.
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

`include "assert_macros.svh"

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int DW   = (ITEM_WIDTH > DATA_W) ? ITEM_WIDTH : DATA_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDWAIT = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [ITEM_WIDTH-1:0] key_r, key_nxt;
  out_t                  out_r, out_nxt;
  logic                  strobe_r, strobe_nxt;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  accept;
  logic                  full;
  logic [ITEM_WIDTH-1:0] in_val;
  logic [CMPW-1:0]       pos_ext, cnt_ext, pos_m1, idx_inc_ext, cnt_nxt_ext;
  logic [CW-1:0]         idx_inc;
  logic [AW-1:0]         addr_inc;
  logic [DW-1:0]         val_ext, rd_ext;

  // Ring slot of the item at a given offset from the head.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, off};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  bdq_ring_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(ITEM_WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && (state_r == S_IDLE);
  assign full       = (count_r == CW'(CAPACITY));
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  // Items live in their low ITEM_WIDTH bits; the value field is taken unsigned.
  assign val_ext     = DW'($unsigned(in_item.value));
  assign in_val      = val_ext[ITEM_WIDTH-1:0];
  assign rd_ext      = DW'(mem_rdata);
  assign pos_ext     = CMPW'(in_item.position);
  assign cnt_ext     = CMPW'(count_r);
  assign pos_m1      = pos_ext - CMPW'(1);
  assign idx_inc     = idx_r + CW'(1);
  assign idx_inc_ext = CMPW'(idx_inc);
  assign cnt_nxt_ext = CMPW'(count_nxt);
  assign addr_inc    = (addr_r == AW'(CAPACITY - 1)) ? '0 : addr_r + AW'(1);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    key_nxt    = key_r;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = in_val;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    out_nxt                = out_r;
    out_nxt.data           = '1;
    out_nxt.found          = 1'b0;
    out_nxt.match_position = '0;
    out_nxt.status         = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          unique case (in_item.operation)
            OP_PUSH_FRONT: begin
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
                mem_we    = 1'b1;
                mem_waddr = head_nxt;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_r, count_r[AW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                head_nxt  = slot_of(head_r, AW'(1));
                count_nxt = count_r - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_READ: begin
              if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                out_nxt.status = ST_MISS;
              end else begin
                strobe_nxt = 1'b0;
                mem_re     = 1'b1;
                mem_raddr  = slot_of(head_r, pos_m1[AW-1:0]);
                state_nxt  = S_RDWAIT;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                out_nxt.status = ST_MISS;
              end else begin
                strobe_nxt = 1'b0;
                mem_re     = 1'b1;
                mem_raddr  = head_r;
                addr_nxt   = head_r;
                idx_nxt    = '0;
                key_nxt    = in_val;
                state_nxt  = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        strobe_nxt   = 1'b1;
        out_nxt.data = rd_ext[DATA_W-1:0];
        state_nxt    = S_IDLE;
      end
      S_SEARCH: begin
        // The RAM output holds the item at offset idx_r; the next read is
        // issued in the same cycle so the walk advances one item per cycle.
        if (mem_rdata == key_r) begin
          strobe_nxt             = 1'b1;
          out_nxt.found          = 1'b1;
          out_nxt.match_position = idx_inc_ext[POS_W-1:0];
          state_nxt              = S_IDLE;
        end else if (idx_inc == count_r) begin
          strobe_nxt     = 1'b1;
          out_nxt.status = ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          addr_nxt  = addr_inc;
          mem_re    = 1'b1;
          mem_raddr = addr_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.item_count = cnt_nxt_ext[POS_W-1:0];
    out_nxt.is_empty   = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    addr_r <= addr_nxt;
    key_r  <= key_nxt;
    out_r  <= out_nxt;
  end

  `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `ASSERT_IMPLY(a_full_drop, clk, rst_n, strobe_r && (out_r.status == ST_FULL), full)
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && (in_item.operation == OP_CLEAR), count_r == '0)
  `ASSERT_NEXT(a_short_ops_free, clk, rst_n, accept && (in_item.operation != OP_READ) && (in_item.operation != OP_SEARCH), !busy && strobe_r)

endmodule
